>>> hw/rtl/lfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared constants, types and helpers for the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int FRAME_BUF_DEPTH = 64;
    localparam int RAM_AW          = $clog2(FRAME_BUF_DEPTH);
    localparam int CNT_W           = 6;
    localparam int LIMIT_CAP_INT   = (FRAME_BUF_DEPTH < 64) ? FRAME_BUF_DEPTH : 64;

    localparam logic [7:0]       HDR_FIRST      = 8'hEF;
    localparam logic [7:0]       HDR_SECOND     = 8'h01;
    localparam logic [CNT_W-1:0] LEN_POS        = CNT_W'(8);
    localparam logic [8:0]       FRAME_OVERHEAD = 9'd9;
    localparam logic [6:0]       LIMIT_RESET    = 7'd60;
    localparam logic [6:0]       LIMIT_CAP      = 7'(LIMIT_CAP_INT);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_HDR,
        ST_BODY,
        ST_READ,
        ST_SHOW
    } lfr_state_t;

    typedef struct packed {
        logic hunt;
        logic start;
        logic store;
        logic inc;
        logic clr;
        logic load_total;
        logic rd;
        logic rd_next;
    } lfr_cmd_t;

    typedef struct packed {
        logic start_ok;
        logic at_len;
        logic len_bad;
        logic count_end;
    } lfr_status_t;

    function automatic logic [RAM_AW-1:0] to_addr(input logic [CNT_W-1:0] pos);
        return RAM_AW'(pos);
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lfr_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_ifs
// Request channels of the frame receiver: input bytes, frame bytes, limit.
// ----------------------------------------------------------------------------
interface lfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [5:0] byte_index;
    logic       last_byte;

    modport source (output valid, output frame_byte, output byte_index,
                    output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input byte_index,
                    input last_byte, output ready);
endinterface

interface lfr_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] frame_total_limit;

    modport source (output valid, output frame_total_limit, input ready);
    modport sink   (input valid, input frame_total_limit, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lfr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> hw/rtl/lfr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_datapath
// Frame store, byte counter, length check and limit register.
// ----------------------------------------------------------------------------
module lfr_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lfr_pkg::lfr_cmd_t   cmd,
    input  wire logic [7:0]          rx_byte,
    input  wire logic                cfg_wr,
    input  wire logic [6:0]          cfg_data,
    output lfr_pkg::lfr_status_t     status,
    output logic [7:0]               frame_byte,
    output logic [5:0]               byte_index,
    output logic                     last_byte
);
    import lfr_pkg::*;

    logic [6:0]       limit_reg;
    logic             hs_reg;
    logic             hs_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] count_inc;
    logic [6:0]       eff_limit;
    logic [8:0]       len_total;
    logic             is_first;
    logic             wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [RAM_AW-1:0] rd_addr;

    assign is_first  = (rx_byte == HDR_FIRST);
    assign count_inc = count_reg + CNT_W'(1);
    assign eff_limit = (limit_reg > LIMIT_CAP) ? LIMIT_CAP : limit_reg;
    assign len_total = {1'b0, rx_byte} + FRAME_OVERHEAD;

    assign status.start_ok  = hs_reg && (rx_byte == HDR_SECOND);
    assign status.at_len    = (count_reg == LEN_POS);
    assign status.len_bad   = (rx_byte == 8'd0) || (len_total >= {2'b00, eff_limit});
    assign status.count_end = (count_inc == total_reg);

    always_comb
    begin
        hs_next = hs_reg;
        if (cmd.hunt)
        begin
            hs_next = is_first;
        end
        else if (cmd.start || cmd.clr)
        begin
            hs_next = 1'b0;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr)
        begin
            count_next = '0;
        end
        else if (cmd.start)
        begin
            count_next = CNT_W'(2);
        end
        else if (cmd.inc)
        begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            hs_reg    <= 1'b0;
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                limit_reg <= cfg_data;
            end
            hs_reg    <= hs_next;
            count_reg <= count_next;
            if (cmd.load_total)
            begin
                total_reg <= CNT_W'(len_total);
            end
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = to_addr(count_reg);
        if (cmd.start)
        begin
            wr_en   = 1'b1;
            wr_addr = to_addr(CNT_W'(1));
        end
        else if (cmd.hunt)
        begin
            wr_en   = is_first;
            wr_addr = to_addr(CNT_W'(0));
        end
        else if (cmd.store)
        begin
            wr_en = 1'b1;
        end
    end

    assign rd_addr = cmd.rd_next ? to_addr(count_inc) : to_addr(count_reg);

    lfr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BUF_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (cmd.rd || cmd.rd_next),
        .rd_addr (rd_addr),
        .rd_data (frame_byte)
    );

    assign byte_index = count_reg;
    assign last_byte  = status.count_end;

endmodule
`default_nettype wire

>>> hw/rtl/lfr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_ctrl
// Frame receiver controller: header hunt, field gathering, frame readout.
// ----------------------------------------------------------------------------
module lfr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 out_ready,
    input  wire lfr_pkg::lfr_status_t status,
    output logic                      in_ready,
    output logic                      out_valid,
    output lfr_pkg::lfr_cmd_t         cmd
);
    import lfr_pkg::*;

    lfr_state_t state_reg;
    lfr_state_t state_next;
    logic       in_fire;

    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT:
            begin
                if (in_fire && status.start_ok)
                begin
                    state_next = ST_HDR;
                end
            end
            ST_HDR:
            begin
                if (in_fire && status.at_len)
                begin
                    state_next = status.len_bad ? ST_HUNT : ST_BODY;
                end
            end
            ST_BODY:
            begin
                if (in_fire && status.count_end)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_ready && status.count_end)
                begin
                    state_next = ST_HUNT;
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_HUNT:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.start = status.start_ok;
                    cmd.hunt  = !status.start_ok;
                end
            end
            ST_HDR:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.store = 1'b1;
                    if (status.at_len && status.len_bad)
                    begin
                        cmd.clr = 1'b1;
                    end
                    else
                    begin
                        cmd.inc        = 1'b1;
                        cmd.load_total = status.at_len;
                    end
                end
            end
            ST_BODY:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.store = 1'b1;
                    cmd.clr   = status.count_end;
                    cmd.inc   = !status.count_end;
                end
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.clr     = status.count_end;
                    cmd.rd_next = !status.count_end;
                    cmd.inc     = !status.count_end;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output requests open together");

    a_close_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BODY && in_fire && status.count_end) |=> (state_reg == ST_READ))
        else $error("closing byte did not start readout");

    a_read_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_SHOW && out_valid))
        else $error("read cycle not followed by output");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHOW && !out_ready) |=> (state_reg == ST_SHOW && !cmd.start))
        else $error("stalled readout left output state");

endmodule
`default_nettype wire

>>> hw/rtl/length_prefixed_frame_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Hunts for the 0xEF 0x01 header, gathers a length-prefixed frame and
// replays the stored frame byte by byte with its index and a last marker.
// ----------------------------------------------------------------------------
// rx_ch.ready is held high while the header is hunted and a frame is received.
// After the closing byte a read state fetches byte 0; the first byte is then valid;
// then one byte per cycle while frame_ch.ready holds, paced by the registered read.
// Input is held off meanwhile, through the read state and every stall.
// Reset clears control state and loads the limit with 60; the frame store
// is not cleared and needs no clearing pass.
module length_prefixed_frame_receiver (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lfr_in_if.sink     rx_ch,
    lfr_out_if.source  frame_ch,
    lfr_cfg_if.sink    cfg
);
    import lfr_pkg::*;

    lfr_cmd_t    cmd;
    lfr_status_t status;

    assign cfg.ready = 1'b1;

    lfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx_ch.valid),
        .out_ready (frame_ch.ready),
        .status    (status),
        .in_ready  (rx_ch.ready),
        .out_valid (frame_ch.valid),
        .cmd       (cmd)
    );

    lfr_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rx_byte    (rx_ch.rx_byte),
        .cfg_wr     (cfg.valid),
        .cfg_data   (cfg.frame_total_limit),
        .status     (status),
        .frame_byte (frame_ch.frame_byte),
        .byte_index (frame_ch.byte_index),
        .last_byte  (frame_ch.last_byte)
    );

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for length_prefixed_frame_receiver. Byte requests go in
// with random gaps and the replay side stalls at random. A behavioral copy of
// the receiver predicts every replayed frame byte, and each one that arrives
// is compared field by field. The bench covers header hunting, length
// bounds, a sweep of the frame limit, a limit change in mid-frame and random
// traffic.
// ----------------------------------------------------------------------------
module testbench;

    localparam int         CYCLE_LIMIT          = 200000;
    localparam int         SETTLE_CYCLES        = 8;
    localparam int         RANDOM_ITEMS         = 50;
    localparam int         QUIET_TAIL           = 15;
    localparam logic [7:0] SYNC_A               = 8'hEF;
    localparam logic [7:0] SYNC_B               = 8'h01;
    localparam int         LENGTH_POS           = 8;
    localparam int         FIELD_BYTES          = 6;
    localparam int         FRAME_OVERHEAD_BYTES = 9;
    localparam int         TOTAL_CAP            = 64;
    localparam logic [6:0] LIMIT_AT_RESET       = 7'd60;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_FIELDS,
        PH_BODY
    } rx_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] index;
        logic       last;
    } frame_byte_t;

    logic clk;
    logic rst_n;

    lfr_in_if  rx_if ();
    lfr_out_if frame_if ();
    lfr_cfg_if cfg_if ();

    length_prefixed_frame_receiver dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_ch    (rx_if),
        .frame_ch (frame_if),
        .cfg      (cfg_if)
    );

    rx_phase_t   rx_phase;
    logic        sync_seen;
    int          fill_count;
    int          frame_total;
    logic [6:0]  limit_reg;
    logic [7:0]  frame_mem [TOTAL_CAP];
    frame_byte_t replay_due [$];

    int mismatches;
    int frame_items;
    bit idle_on;
    int stall_left;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int limit_in_force();
        return (int'(limit_reg) > TOTAL_CAP) ? TOTAL_CAP : int'(limit_reg);
    endfunction

    function automatic void restart_hunt();
        rx_phase   = PH_HUNT;
        sync_seen  = 1'b0;
        fill_count = 0;
    endfunction

    function automatic void predict_rx(input logic [7:0] b);
        frame_byte_t e;
        case (rx_phase)
            PH_HUNT:
            begin
                if (sync_seen && b == SYNC_B)
                begin
                    frame_mem[0] = SYNC_A;
                    frame_mem[1] = SYNC_B;
                    fill_count   = 2;
                    sync_seen    = 1'b0;
                    rx_phase     = PH_FIELDS;
                end
                else
                begin
                    sync_seen = (b == SYNC_A);
                end
            end
            PH_FIELDS:
            begin
                frame_mem[fill_count] = b;
                if (fill_count == LENGTH_POS)
                begin
                    if (b == 8'd0 || int'(b) + FRAME_OVERHEAD_BYTES >= limit_in_force())
                    begin
                        restart_hunt();
                    end
                    else
                    begin
                        frame_total = int'(b) + FRAME_OVERHEAD_BYTES;
                        fill_count  = LENGTH_POS + 1;
                        rx_phase    = PH_BODY;
                    end
                end
                else
                begin
                    fill_count++;
                end
            end
            PH_BODY:
            begin
                frame_mem[fill_count] = b;
                fill_count++;
                if (fill_count == frame_total)
                begin
                    for (int k = 0; k < frame_total; k++)
                    begin
                        e.data  = frame_mem[k];
                        e.index = 6'(k);
                        e.last  = (k == frame_total - 1);
                        replay_due.push_back(e);
                    end
                    restart_hunt();
                end
            end
            default:
            begin
                restart_hunt();
            end
        endcase
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic void check_replay(input frame_byte_t got);
        frame_byte_t want;
        if (replay_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected byte %02h index %0d last %0b",
                                      got.data, got.index, got.last));
        end
        else
        begin
            want = replay_due.pop_front();
            if (got !== want)
            begin
                report_mismatch($sformatf(
                    "expected byte %02h index %0d last %0b, got byte %02h index %0d last %0b",
                    want.data, want.index, want.last, got.data, got.index, got.last));
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && frame_if.valid && frame_if.ready)
        begin
            check_replay({frame_if.frame_byte, frame_if.byte_index, frame_if.last_byte});
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            frame_if.ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            frame_if.ready <= 1'b0;
            stall_left     <= $urandom_range(0, 5);
        end
        else
        begin
            frame_if.ready <= 1'b1;
        end
    end

    task automatic push_rx(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        predict_rx(b);
    endtask

    task automatic settle();
        rx_if.valid <= 1'b0;
        while (replay_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [6:0] v);
        settle();
        cfg_if.valid             <= 1'b1;
        cfg_if.frame_total_limit <= v;
        do @(posedge clk); while (!cfg_if.ready);
        limit_reg = v;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic push_header_fields();
        push_rx(SYNC_A);
        push_rx(SYNC_B);
        repeat (FIELD_BYTES) push_rx(8'($urandom_range(0, 255)));
    endtask

    // cut: stop the body early so the next request lands inside the frame
    task automatic send_frame(input logic [7:0] len, input bit cut);
        int n;
        push_header_fields();
        push_rx(len);
        if (len != 8'd0 && int'(len) + FRAME_OVERHEAD_BYTES < limit_in_force())
        begin
            n = cut ? $urandom_range(0, int'(len) - 1) : int'(len);
            repeat (n) push_rx(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(0, 3);
            repeat (n) push_rx(8'($urandom_range(2, 8'hEE)));
        end
        frame_items += FRAME_OVERHEAD_BYTES + n;
    endtask

    task automatic test_header_hunt();
        push_rx(SYNC_B);
        push_rx(SYNC_A);
        push_rx(8'h33);
        push_rx(SYNC_B);
        push_rx(SYNC_A);
        send_frame(8'd1, 1'b0);
    endtask

    task automatic test_length_bounds();
        send_frame(8'd0, 1'b0);
        send_frame(8'hFF, 1'b0);
    endtask

    task automatic test_limit_sweep();
        logic [6:0] sweep [4] = '{7'd127, 7'd11, 7'd10, 7'd20};
        int longest;
        foreach (sweep[i])
        begin
            set_limit(sweep[i]);
            longest = limit_in_force() - FRAME_OVERHEAD_BYTES - 1;
            if (longest >= 1)
            begin
                send_frame(8'(longest), 1'b0);
            end
            send_frame(8'((longest < 1) ? 1 : longest + 1), 1'b0);
        end
    endtask

    task automatic test_midframe_limit();
        for (int r = 0; r < 2; r++)
        begin
            push_header_fields();
            set_limit((r == 0) ? 7'd20 : 7'd21);
            push_rx(8'd11);
            if (r == 1)
            begin
                repeat (11) push_rx(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_traffic();
        int next_retune;
        int pick;
        int longest;
        logic [7:0] noise;
        frame_items = 0;
        next_retune = 25;
        set_limit(7'($urandom_range(30, 127)));
        while (frame_items < RANDOM_ITEMS)
        begin
            if (frame_items >= RANDOM_ITEMS - QUIET_TAIL)
            begin
                idle_on = 1'b0;
            end
            if (frame_items >= next_retune)
            begin
                set_limit(7'($urandom_range(11, 127)));
                next_retune += 25;
            end
            pick    = $urandom_range(0, 9);
            longest = limit_in_force() - FRAME_OVERHEAD_BYTES - 1;
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 3))
                        0:       noise = SYNC_A;
                        1:       noise = SYNC_B;
                        default: noise = 8'($urandom_range(0, 255));
                    endcase
                    push_rx(noise);
                end
            end
            else if (pick == 1 || longest < 1)
            begin
                send_frame(8'($urandom_range(0, 255)), 1'b1);
            end
            else if (pick == 2)
            begin
                send_frame(8'($urandom_range(1, longest)), 1'b1);
            end
            else if ($urandom_range(0, 7) != 0)
            begin
                send_frame(8'($urandom_range(1, (longest < 12) ? longest : 12)), 1'b0);
            end
            else
            begin
                send_frame(8'($urandom_range(1, longest)), 1'b0);
            end
        end
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        rx_if.valid              = 1'b0;
        rx_if.rx_byte            = 8'd0;
        cfg_if.valid             = 1'b0;
        cfg_if.frame_total_limit = 7'd0;
        idle_on                  = 1'b1;
        mismatches               = 0;
        frame_items              = 0;
        frame_total              = 0;
        limit_reg                = LIMIT_AT_RESET;
        restart_hunt();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_header_hunt();
        test_length_bounds();
        test_limit_sweep();
        test_midframe_limit();
        test_random_traffic();
        settle();

        if (mismatches == 0 && replay_due.size() == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/lfr_pkg.sv
hw/rtl/lfr_ifs.sv
hw/rtl/lfr_ram.sv
hw/rtl/lfr_datapath.sv
hw/rtl/lfr_ctrl.sv
hw/rtl/length_prefixed_frame_receiver.sv
verif/testbench.sv
